[rtl/sth_pkg.sv]
`timescale 1ns / 1ps

package sth_pkg;

    localparam int BIN_COUNT_DEF = 256;
    localparam int MAG_BITS_DEF  = 24;
    localparam int BIN_W         = 8;
    localparam int FRAC_BITS     = 3;
    localparam int MODE_W        = 2;

    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;

endpackage

[rtl/spectrum_trace_hold.sv]
`timescale 1ns / 1ps
// An input beat passes through stage 1 and then the output register to the master side; stalls hold it there.
// One bin per cycle while the master side takes results, set by one read-modify-write of the bin store per beat
// (one read port, one write port, back-to-back hits on one bin are forwarded).
// Reset (synchronous, active low): mode off, primed and priming flags clear,
// running peak 1, pipeline empty. The bin store is not cleared; it is loaded by priming.
module spectrum_trace_hold
    import sth_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF,
    parameter int MAG_BITS  = MAG_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: hold_mode
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [MODE_W-1:0]          i_cfg_data,
    // bins in
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, low bit up: magnitude[MAG_BITS], bin_index[8], zero pad to bytes
    input  logic [((MAG_BITS+BIN_W+7)/8)*8-1:0] s_axis_tdata,
    input  logic                       s_axis_tlast,   // last_bin
    input  logic                       s_axis_tuser,   // restart
    // results out
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata, low bit up: shown_magnitude[MAG_BITS], frame_peak[MAG_BITS], zero pad
    output logic [((2*MAG_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                       m_axis_tlast    // frame_done
);

    localparam int ADDR_W = $clog2(BIN_COUNT);
    localparam int ST_W   = MAG_BITS + FRAC_BITS;
    localparam int OUT_W  = ((2*MAG_BITS+7)/8)*8;
    localparam logic [ST_W:0] ROUND_UP = (ST_W+1)'((1 << FRAC_BITS) - 1);

    // Bin store: one read port (issued on input beat), one write port (from stage 1).
    logic [ST_W-1:0] r_mem [BIN_COUNT];
    logic [ST_W-1:0] r_mem_q;

    // control / config
    logic [MODE_W-1:0] r_mode;
    logic              r_primed, n_primed;
    logic              r_priming, n_priming;
    logic [MAG_BITS-1:0] r_peak, n_peak;

    // stage 1: item waiting on its store read
    logic                r_s1_valid;
    logic [MAG_BITS-1:0] r_s1_mag;
    logic [BIN_W-1:0]    r_s1_bin;
    logic                r_s1_restart;
    logic                r_s1_last;
    logic                r_fwd_hit;
    logic [ST_W-1:0]     r_fwd_val;

    // output register
    logic                r_out_valid;
    logic [MAG_BITS-1:0] r_out_shown;
    logic [MAG_BITS-1:0] r_out_peak;
    logic                r_out_last;

    logic                in_beat;
    logic                s1_adv;
    logic [MAG_BITS-1:0] in_mag;
    logic [BIN_W-1:0]    in_bin;
    logic [ADDR_W-1:0]   in_addr;
    logic [ADDR_W-1:0]   s1_addr;

    logic                active;
    logic                in_range;
    logic                s1_write;
    logic                p0, pf0, pf1;
    logic [MAG_BITS-1:0] peak0;
    logic [ST_W-1:0]     target, s_old, s_new;
    logic [ST_W-1:0]     up_step;
    logic [ST_W:0]       down_sum;
    logic [MAG_BITS-1:0] shown;

    assign o_cfg_ready   = 1'b1;
    assign in_mag        = s_axis_tdata[MAG_BITS-1:0];
    assign in_bin        = s_axis_tdata[MAG_BITS +: BIN_W];
    assign in_addr       = ADDR_W'(in_bin);
    assign s1_addr       = ADDR_W'(r_s1_bin);

    // Stage 1 moves on when the output register is free or being drained.
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // ---------------- hold processing for the bin in stage 1 ----------------
    always_comb begin
        active   = (r_mode == MODE_MAX) || (r_mode == MODE_AVG);
        in_range = 32'(r_s1_bin) < BIN_COUNT;
        s1_write = active && in_range;

        // restart clears the flags before the bin is handled
        p0  = r_s1_restart ? 1'b0 : r_primed;
        pf0 = r_s1_restart ? 1'b0 : r_priming;
        pf1 = pf0;
        peak0 = r_peak;
        if (r_s1_bin == '0) begin
            peak0 = MAG_BITS'(1);
            if (active) begin
                pf1 = !p0;
            end
        end

        target   = {r_s1_mag, FRAC_BITS'(0)};
        s_old    = r_fwd_hit ? r_fwd_val : r_mem_q;
        up_step  = (target - s_old) >> FRAC_BITS;
        down_sum = ({1'b0, s_old} - {1'b0, target} + ROUND_UP) >> FRAC_BITS;

        if (pf1 || !p0) begin
            s_new = target;
        end else if (r_mode == MODE_MAX) begin
            s_new = (target > s_old) ? target : s_old;
        end else if (target >= s_old) begin
            s_new = s_old + up_step;
        end else begin
            s_new = s_old - down_sum[ST_W-1:0];
        end

        shown = s1_write ? s_new[ST_W-1:FRAC_BITS] : r_s1_mag;

        n_primed  = p0;
        n_priming = pf1;
        if (active && r_s1_last && pf1) begin
            n_primed  = 1'b1;
            n_priming = 1'b0;
        end

        n_peak = peak0;
        if ((r_s1_bin != '0) && (shown > peak0)) begin
            n_peak = shown;
        end
    end

    // ---------------- bin store ----------------
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_mem_q <= r_mem[in_addr];
        end
        if (s1_adv && s1_write) begin
            r_mem[s1_addr] <= s_new;
        end
    end

    // Forward a write that lands in the same cycle as the next read of that bin.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_fwd_hit <= s1_adv && s1_write && (r_s1_bin == in_bin);
            r_fwd_val <= s_new;
        end
    end

    // ---------------- stage 1 payload ----------------
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_mag     <= in_mag;
            r_s1_bin     <= in_bin;
            r_s1_restart <= s_axis_tuser;
            r_s1_last    <= s_axis_tlast;
        end
    end

    // ---------------- output payload ----------------
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_shown <= shown;
            r_out_peak  <= n_peak;
            r_out_last  <= r_s1_last;
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_primed    <= 1'b0;
            r_priming   <= 1'b0;
            r_peak      <= MAG_BITS'(1);
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // mode write drops any priming progress
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode    <= i_cfg_data;
                r_primed  <= 1'b0;
                r_priming <= 1'b0;
            end else if (s1_adv) begin
                r_primed  <= n_primed;
                r_priming <= n_priming;
            end

            if (s1_adv) begin
                r_peak <= n_peak;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_peak, r_out_shown});
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/sth_checker.sv]
`timescale 1ns / 1ps

module sth_checker
    import sth_pkg::*;
#(
    parameter int MAG_BITS = MAG_BITS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [MODE_W-1:0]          i_cfg_data,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [((MAG_BITS+BIN_W+7)/8)*8-1:0] s_axis_tdata,
    input logic                       s_axis_tlast,
    input logic                       s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [((2*MAG_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic                       m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // peak has a floor of one
    a_peak_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2*MAG_BITS-1:MAG_BITS] != '0))
        else $error("frame peak is zero");

    // an empty pipeline refills only from an earlier input beat that went through stage 1
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without input beat");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind spectrum_trace_hold sth_checker #(.MAG_BITS(MAG_BITS)) u_sth_checker (.*);
